// ===== rtl/backslash_escape_decoder_unit_macros.svh =====
// Assertion macros for the backslash escape decoder unit.
// Used by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef BACKSLASH_ESCAPE_DECODER_UNIT_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bed same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define BED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bed next-cycle check failed");

`endif

// ===== rtl/bed_pkg.sv =====
// Shared types and constants for the backslash escape decoder unit.
// No dependencies; used by bed_decoder, bed_burst_out and the top level.
package bed_pkg;

    // Parser phase codes
    typedef enum logic [2:0] {
        PH_TEXT  = 3'd0,
        PH_ESC   = 3'd1,
        PH_BRACE = 3'd2,
        PH_HEX   = 3'd3
    } t_phase;

    localparam int unsigned BURST_MAX = 4;
    localparam int unsigned CNT_W     = $clog2(BURST_MAX + 1);

    localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;
    localparam logic [3:0]  HEX_TEN        = 4'hA;

    // Characters the parser looks for
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // One decoded item: up to four bytes, plus error and string-end flags
    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        logic [BURST_MAX-1:0][7:0]  bytes;
        logic                       err;
        logic                       str_end;
    } t_burst;

endpackage

// ===== rtl/backslash_escape_decoder_unit.sv =====
// Backslash escape decoder. Takes one byte of a string body per cycle and
// gives unescaped UTF-8 bytes, one result beat per cycle while the receiver is
// ready. A byte is held in an input register while it is decoded and its
// results (0 to 4 beats) are loaded into the result register, from which the
// first result of a byte is presented; a result register still busy with
// earlier beats stalls that load. The input side takes a new byte every
// cycle as long as each byte yields at most one beat and the receiver keeps
// up; a byte yielding several beats holds the result register until its last
// beat is taken, which sets the rate for escapes that expand to multi-byte
// UTF-8. A failed string gives a single error beat on its final byte.
// Depends on bed_pkg, bed_decoder and bed_burst_out.
module backslash_escape_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_string_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_status,
    output logic       o_run_last,
    output logic       o_string_end
);

    bed_pkg::t_burst burst;
    logic            burst_valid;
    logic            burst_ready;

    // Parser and decode
    bed_decoder u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_string_last (i_string_last),
        .o_burst_valid (burst_valid),
        .i_burst_ready (burst_ready),
        .o_burst       (burst)
    );

    // Result register and beat sequencing
    bed_burst_out u_burst_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst_valid (burst_valid),
        .o_burst_ready (burst_ready),
        .i_burst       (burst),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_run_last    (o_run_last),
        .o_string_end  (o_string_end)
    );

endmodule

// ===== rtl/bed_decoder.sv =====
// Input register, parser state and escape/UTF-8 decode for one byte per cycle when not stalled.
// Depends on bed_pkg; feeds a t_burst into bed_burst_out.
module bed_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_in_byte,
    input  logic            i_string_last,
    output logic            o_burst_valid,
    input  logic            i_burst_ready,
    output bed_pkg::t_burst o_burst
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;

    bed_pkg::t_phase      r_phase, n_phase;
    logic [31:0]          r_acc, n_acc;
    logic                 r_err, n_err;

    bed_pkg::t_burst      burst;
    logic                 take;

    // Single-character escapes: {hit, byte}
    function automatic logic [8:0] simple_esc(input logic [7:0] b);
        logic [8:0] res;
        res = 9'd0;
        case (b)
            8'h6E: res = {1'b1, 8'h0A}; // n
            8'h72: res = {1'b1, 8'h0D}; // r
            8'h74: res = {1'b1, 8'h09}; // t
            8'h5C: res = {1'b1, 8'h5C}; // backslash
            8'h2F: res = {1'b1, 8'h2F}; // slash
            8'h22: res = {1'b1, 8'h22}; // double quote
            8'h62: res = {1'b1, 8'h08}; // b
            8'h66: res = {1'b1, 8'h0C}; // f
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    // Hex digit value: {hit, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] res;
        res = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            res = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            res = {1'b1, 4'(b[2:0] - 3'd1) + bed_pkg::HEX_TEN};
        end
        return res;
    endfunction

    // Next state and result burst for the held byte
    always_comb begin
        logic [8:0] esc;
        logic [4:0] hx;
        esc     = simple_esc(r_in_byte);
        hx      = hex_val(r_in_byte);
        n_phase = r_phase;
        n_acc   = r_acc;
        n_err   = r_err;
        burst   = '0;
        if (!r_err) begin
            unique case (r_phase)
                bed_pkg::PH_ESC: begin
                    if (esc[8]) begin
                        burst.cnt      = bed_pkg::CNT_W'(1);
                        burst.bytes[0] = esc[7:0];
                        n_phase        = bed_pkg::PH_TEXT;
                    end else if (r_in_byte == bed_pkg::CH_U) begin
                        n_phase = bed_pkg::PH_BRACE;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                bed_pkg::PH_BRACE: begin
                    if (r_in_byte == bed_pkg::CH_LBRACE) begin
                        n_phase = bed_pkg::PH_HEX;
                        n_acc   = 32'd0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                bed_pkg::PH_HEX: begin
                    if (r_in_byte == bed_pkg::CH_RBRACE) begin
                        n_phase = bed_pkg::PH_TEXT;
                        // UTF-8 encode of the gathered code point
                        if (r_acc < 32'h80) begin
                            burst.cnt      = bed_pkg::CNT_W'(1);
                            burst.bytes[0] = r_acc[7:0];
                        end else if (r_acc < 32'h800) begin
                            burst.cnt      = bed_pkg::CNT_W'(2);
                            burst.bytes[0] = {3'b110, r_acc[10:6]};
                            burst.bytes[1] = {2'b10, r_acc[5:0]};
                        end else if (r_acc < 32'h1_0000) begin
                            burst.cnt      = bed_pkg::CNT_W'(3);
                            burst.bytes[0] = {4'b1110, r_acc[15:12]};
                            burst.bytes[1] = {2'b10, r_acc[11:6]};
                            burst.bytes[2] = {2'b10, r_acc[5:0]};
                        end else if (r_acc <= bed_pkg::MAX_CODE_POINT) begin
                            burst.cnt      = bed_pkg::CNT_W'(4);
                            burst.bytes[0] = {5'b11110, r_acc[20:18]};
                            burst.bytes[1] = {2'b10, r_acc[17:12]};
                            burst.bytes[2] = {2'b10, r_acc[11:6]};
                            burst.bytes[3] = {2'b10, r_acc[5:0]};
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (hx[4]) begin
                        n_acc = {r_acc[27:0], hx[3:0]};
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    // text phase; unused codes behave the same
                    if (r_in_byte == bed_pkg::CH_BSLASH) begin
                        n_phase = bed_pkg::PH_ESC;
                    end else begin
                        burst.cnt      = bed_pkg::CNT_W'(1);
                        burst.bytes[0] = r_in_byte;
                    end
                end
            endcase
        end

        // string ending inside an escape fails it
        if (r_in_last && !n_err && n_phase != bed_pkg::PH_TEXT) begin
            n_err = 1'b1;
        end

        // failed string: only its final byte gives one error beat
        if (n_err) begin
            burst       = '0;
            burst.err   = 1'b1;
            burst.cnt   = r_in_last ? bed_pkg::CNT_W'(1) : bed_pkg::CNT_W'(0);
        end
        burst.str_end = r_in_last;

        // end of string restores reset state
        if (r_in_last) begin
            n_phase = bed_pkg::PH_TEXT;
            n_acc   = 32'd0;
            n_err   = 1'b0;
        end
    end

    assign take          = r_in_valid && (burst.cnt == '0 || i_burst_ready);
    assign o_ready       = !r_in_valid || take;
    assign o_burst_valid = r_in_valid && (burst.cnt != '0);
    assign o_burst       = burst;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_string_last;
        end
    end

    // Parser state, advanced once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bed_pkg::PH_TEXT;
            r_acc   <= 32'd0;
            r_err   <= 1'b0;
        end else if (take) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_err   <= n_err;
        end
    end

endmodule

// ===== rtl/bed_burst_out.sv =====
// Result register: holds one decoded burst and sends it one beat per cycle while i_ready is high.
// Depends on bed_pkg and the assertion macro header.
`include "backslash_escape_decoder_unit_macros.svh"

module bed_burst_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_burst_valid,
    output logic            o_burst_ready,
    input  bed_pkg::t_burst i_burst,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_status,
    output logic            o_run_last,
    output logic            o_string_end
);

    logic [bed_pkg::CNT_W-1:0]          r_left;
    logic [bed_pkg::BURST_MAX-1:0][7:0] r_bytes;
    logic                               r_err;
    logic                               r_end;
    logic                               load;
    logic                               pop;

    assign o_valid       = (r_left != '0);
    assign pop           = o_valid && i_ready;
    assign o_burst_ready = (r_left == '0) ||
                           (r_left == bed_pkg::CNT_W'(1) && i_ready);
    assign load          = i_burst_valid && o_burst_ready;

    assign o_out_byte    = r_bytes[0];
    assign o_status      = r_err;
    assign o_run_last    = (r_left == bed_pkg::CNT_W'(1));
    assign o_string_end  = r_end && o_run_last;

    // Beat counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= i_burst.cnt;
        end else if (pop) begin
            r_left <= r_left - bed_pkg::CNT_W'(1);
        end
    end

    // Burst bytes shift down one place per beat
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= i_burst.bytes;
            r_err   <= i_burst.err;
            r_end   <= i_burst.str_end;
        end else if (pop) begin
            for (int k = 0; k < bed_pkg::BURST_MAX - 1; k++) begin
                r_bytes[k] <= r_bytes[k+1];
            end
            r_bytes[bed_pkg::BURST_MAX-1] <= 8'h00;
        end
    end

    // Error beat stands alone, carries a zero byte
    `BED_ASSERT_IMP(a_err_beat, i_clk, i_rst_n, o_valid && o_status, o_run_last && o_out_byte == 8'h00)
    // A new burst lands only when the old one is gone or leaving
    `BED_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, load, r_left == '0 || (o_run_last && i_ready))
    // Mid-burst beats are followed by another beat
    `BED_ASSERT_NXT(a_burst_continues, i_clk, i_rst_n, pop && !o_run_last && !i_burst_valid, o_valid)

endmodule
